// ===== sv/erb_pkg.sv =====
// Package of shared types, widths and codes for the eased brightness ramp.
package erb_pkg;

   // Field and register widths
   localparam int LEVEL_W  = 8;
   localparam int LEN_W    = 16;
   localparam int EASE_W   = 8;
   localparam int CHANGE_W = LEVEL_W + 1;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Datapath widths: products and the divider
   localparam int NUM_PROD_W = LEVEL_W + LEN_W;        // |change| * n
   localparam int NK_W       = LEN_W + EASE_W;         // n * k
   localparam int LK_W       = LEN_W + EASE_W + 1;     // N * (256 - k)
   localparam int DEN_W      = LK_W + 1;               // sum of the two
   localparam int REM_W      = NUM_PROD_W + EASE_W;    // |change| * 256 * n
   localparam int DIV_STEPS  = LEVEL_W;                // quotient stays below 256
   localparam int CNT_W      = $clog2(DIV_STEPS);
   localparam int SHIFT_W    = REM_W + 1;

   // Constants
   localparam logic [EASE_W:0]   Q_ONE             = 9'd256;
   localparam logic [LEN_W-1:0]  RAMP_LENGTH_RESET = 16'd50;
   localparam logic [EASE_W-1:0] EASING_RESET      = 8'd128;
   localparam logic [LEVEL_W-1:0] START_RESET      = 8'd100;
   localparam logic [CNT_W-1:0]  CNT_TOP           = CNT_W'(DIV_STEPS - 1);

   // Operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SET  = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EASING      = 2'd1;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_DIV,
      ST_OUT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic load_mul;
      logic load_sum;
      logic div_step;
      logic load_out;
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic ramp_go;
      logic div_last;
   } dp_status_type;

endpackage

// ===== sv/erb_ctrl.sv =====
// Controller state machine for the eased brightness ramp.
module erb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  erb_pkg::dp_status_type status,
   output erb_pkg::ctrl_cmd_type  cmd
);
   import erb_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Output slot is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.ramp_go) state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_MUL:  cmd.load_mul = 1'b1;
         ST_SUM:  cmd.load_sum = 1'b1;
         ST_DIV:  cmd.div_step = 1'b1;
         ST_OUT:  cmd.load_out = out_free;
         default: cmd = '0;
      endcase
   end

   // Hold the result valid until the item is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A running tick enters the multiply step right after acceptance
   a_go_to_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && status.ramp_go) |=> (state_ff == ST_MUL))
      else $error("tick accepted but multiply step not entered");

   // A pending result blocks the write of the next one
   a_out_blocked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_OUT))
      else $error("result overwritten while still pending");

endmodule

// ===== sv/erb_dp.sv =====
// Datapath of the eased brightness ramp: ramp state, products and divider.
module erb_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [erb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [erb_pkg::CSR_DAT_W-1:0]         csr_data,
   input  logic                                  req_operation,
   input  logic [erb_pkg::LEVEL_W-1:0]           req_target,
   input  logic [erb_pkg::LEVEL_W-1:0]           req_current_level,
   output logic [erb_pkg::LEVEL_W-1:0]           rsp_level,
   input  erb_pkg::ctrl_cmd_type                 cmd,
   output erb_pkg::dp_status_type                status
);
   import erb_pkg::*;

   logic [LEN_W-1:0]      ramp_len_ff, ramp_len_in;
   logic [EASE_W-1:0]     easing_ff, easing_in;
   logic [LEN_W-1:0]      step_ff, step_in;
   logic [LEVEL_W-1:0]    start_ff, start_in;
   logic [CHANGE_W-1:0]   change_ff, change_in;
   logic [NUM_PROD_W-1:0] prod_num_ff, prod_num_in;
   logic [NK_W-1:0]       prod_nk_ff, prod_nk_in;
   logic [LK_W-1:0]       prod_lk_ff, prod_lk_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [LEVEL_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;

   logic [LEN_W:0]        n_next;
   logic [CHANGE_W-1:0]   change_neg;
   logic [LEVEL_W-1:0]    mag;
   logic [SHIFT_W-1:0]    den_shift;
   logic                  fits;
   logic [LEVEL_W:0]      up_sum;

   // Advance the count in one extra bit so it never wraps
   assign n_next = {1'b0, step_ff} + {{LEN_W{1'b0}}, 1'b1};
   assign status.ramp_go  = (req_operation == OP_TICK) && (n_next < {1'b0, ramp_len_ff});
   assign status.div_last = (cnt_ff == '0);

   // Magnitude of the signed difference
   assign change_neg = ~change_ff + {{(CHANGE_W-1){1'b0}}, 1'b1};
   assign mag = change_ff[CHANGE_W-1] ? change_neg[LEVEL_W-1:0] : change_ff[LEVEL_W-1:0];

   // Configuration writes
   always_comb begin
      ramp_len_in = ramp_len_ff;
      easing_in   = easing_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RAMP_LENGTH: ramp_len_in = csr_data[LEN_W-1:0];
            CSR_EASING:      easing_in   = csr_data[EASE_W-1:0];
            default:         ramp_len_in = ramp_len_ff;
         endcase
      end
   end

   // Update ramp state on an accepted item
   always_comb begin
      step_in   = step_ff;
      start_in  = start_ff;
      change_in = change_ff;
      if (cmd.accept) begin
         if (req_operation == OP_SET) begin
            step_in   = '0;
            start_in  = req_current_level;
            change_in = {1'b0, req_target} - {1'b0, req_current_level};
         end else if (status.ramp_go) begin
            step_in = n_next[LEN_W-1:0];
         end else begin
            step_in   = ramp_len_ff;
            change_in = '0;
         end
      end
   end

   // Form the three products, one register stage
   always_comb begin
      prod_num_in = prod_num_ff;
      prod_nk_in  = prod_nk_ff;
      prod_lk_in  = prod_lk_ff;
      if (cmd.load_mul) begin
         prod_num_in = mag * step_ff;
         prod_nk_in  = step_ff * easing_ff;
         prod_lk_in  = ramp_len_ff * (Q_ONE - {1'b0, easing_ff});
      end
   end

   // Restoring divider: one quotient bit a cycle, most significant first
   assign den_shift = {{(SHIFT_W-DEN_W){1'b0}}, den_ff} << cnt_ff;
   assign fits      = ({1'b0, rem_ff} >= den_shift);

   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (cmd.load_sum) begin
         rem_in = {prod_num_ff, {EASE_W{1'b0}}};
         den_in = {2'b00, prod_nk_ff} + {1'b0, prod_lk_ff};
         quo_in = '0;
         cnt_in = CNT_TOP;
      end else if (cmd.div_step) begin
         if (fits) rem_in = rem_ff - den_shift[REM_W-1:0];
         quo_in = {quo_ff[LEVEL_W-2:0], fits};
         cnt_in = cnt_ff - {{(CNT_W-1){1'b0}}, 1'b1};
      end
   end

   // Apply the signed step to the start level
   assign up_sum = {1'b0, start_ff} + {1'b0, quo_ff};

   always_comb begin
      level_in = level_ff;
      if (cmd.load_out) begin
         level_in = change_ff[CHANGE_W-1] ? (start_ff - quo_ff) : up_sum[LEVEL_W-1:0];
      end
   end

   assign rsp_level = level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_len_ff <= RAMP_LENGTH_RESET;
         easing_ff   <= EASING_RESET;
         step_ff     <= '0;
         start_ff    <= START_RESET;
         change_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         ramp_len_ff <= ramp_len_in;
         easing_ff   <= easing_in;
         step_ff     <= step_in;
         start_ff    <= start_in;
         change_ff   <= change_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_num_ff <= prod_num_in;
      prod_nk_ff  <= prod_nk_in;
      prod_lk_ff  <= prod_lk_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      quo_ff      <= quo_in;
      level_ff    <= level_in;
   end

   // A rising ramp never passes full brightness
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && !change_ff[CHANGE_W-1]) |-> (up_sum[LEVEL_W] == 1'b0))
      else $error("rising ramp overflowed the level");

   // A falling ramp never goes below zero
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && change_ff[CHANGE_W-1]) |-> (quo_ff <= start_ff))
      else $error("falling ramp underflowed the level");

endmodule

// ===== sv/eased_brightness_ramp.sv =====
// Top level of the eased brightness ramp: controller and datapath.
//
// Input channel (req_*): one item per valid/ready handshake. A set item
// (operation 1) stores current_level as the start, target - start as the
// signed difference and clears the step count; it gives
// no result. A tick item (operation 0) advances the count n; while n stays
// below ramp_length it gives one level, start + difference * 256n /
// (n*k + N*(256-k)) truncated toward zero, otherwise it ends the ramp and
// gives nothing.
// Result channel (rsp_*): rsp_level is held in an output register until the
// receiver takes it. rsp_valid rises after the tick has passed the multiply
// step, the add step, the restoring divider (one quotient bit a cycle) and the
// write of the result. The next item is accepted as soon as the controller
// is back in idle.
// A stalled receiver holds the finished level in the write step until the
// pending result is taken; earlier results are never overwritten.
// Configuration (csr_*): index 0 is ramp_length, index 1 is easing, always
// ready; write only while the block is idle.
// Reset sets ramp_length 50, easing 128, start level 100, no difference.
module eased_brightness_ramp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [erb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [erb_pkg::CSR_DAT_W-1:0]   csr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic [erb_pkg::LEVEL_W-1:0]     req_target,
   input  logic [erb_pkg::LEVEL_W-1:0]     req_current_level,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [erb_pkg::LEVEL_W-1:0]     rsp_level
);
   import erb_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Registers take a write in any cycle
   assign csr_ready = 1'b1;

   erb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   erb_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_operation     (req_operation),
      .req_target        (req_target),
      .req_current_level (req_current_level),
      .rsp_level         (rsp_level),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

// ===== tb/erb_level_checker.sv =====
`timescale 1ns / 100ps
// Checker for the eased brightness ramp: tracks the ramp, predicts each level and compares.
module erb_level_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [erb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [erb_pkg::CSR_DAT_W-1:0] csr_data,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_operation,
   input  logic [erb_pkg::LEVEL_W-1:0]   req_target,
   input  logic [erb_pkg::LEVEL_W-1:0]   req_current_level,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [erb_pkg::LEVEL_W-1:0]   rsp_level,
   output int                            failures,
   output int                            pending_levels
);
   import erb_pkg::*;

   // Shadow copy of the registers and the ramp state
   logic [LEN_W-1:0]           ramp_len;
   logic [EASE_W-1:0]          ease_k;
   logic [LEN_W-1:0]           step_cnt;
   logic [LEVEL_W-1:0]         start_lvl;
   logic signed [CHANGE_W-1:0] level_diff;
   logic [LEVEL_W-1:0]         expected_levels[$];

   // Advance the ramp by one item and queue the level it should give
   task automatic advance_ramp(input logic op, input logic [LEVEL_W-1:0] tgt,
                               input logic [LEVEL_W-1:0] cur);
      logic [LEN_W:0] n;
      longint         d;
      longint         mag;
      longint         num;
      longint         den;
      longint         quot;
      if (op == OP_SET) begin
         step_cnt   = '0;
         start_lvl  = cur;
         level_diff = CHANGE_W'({1'b0, tgt} - {1'b0, cur});
      end else begin
         // count is formed one bit wider, so it never wraps
         n = {1'b0, step_cnt} + 1'b1;
         if (n >= {1'b0, ramp_len}) begin
            // end of ramp: hold the count, drop the difference, no level
            step_cnt   = ramp_len;
            level_diff = '0;
         end else begin
            step_cnt = n[LEN_W-1:0];
            d        = level_diff;
            mag      = (d < 0) ? -d : d;
            num      = mag * longint'(Q_ONE) * longint'(n);
            den      = longint'(n) * longint'(ease_k)
                     + longint'(ramp_len) * (longint'(Q_ONE) - longint'(ease_k));
            quot     = num / den;
            if (d < 0)
               expected_levels.push_back(start_lvl - LEVEL_W'(quot));
            else
               expected_levels.push_back(start_lvl + LEVEL_W'(quot));
         end
      end
   endtask

   // Compare results first, then take register writes and new items
   always @(posedge clock) begin
      logic [LEVEL_W-1:0] want;
      if (reset) begin
         ramp_len   = RAMP_LENGTH_RESET;
         ease_k     = EASING_RESET;
         step_cnt   = '0;
         start_lvl  = START_RESET;
         level_diff = '0;
         failures   = 0;
         expected_levels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: level %0d arrived with none expected", $time, rsp_level);
               failures++;
            end else begin
               want = expected_levels.pop_front();
               if (rsp_level !== want) begin
                  $display("%0t: level mismatch, expected %0d, actual %0d",
                           $time, want, rsp_level);
                  failures++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RAMP_LENGTH: ramp_len = csr_data[LEN_W-1:0];
               CSR_EASING:      ease_k   = csr_data[EASE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            advance_ramp(req_operation, req_target, req_current_level);
      end
      pending_levels = expected_levels.size();
   end

endmodule

// ===== tb/eased_brightness_ramp_tb.sv =====
`timescale 1ns / 100ps
// Top of the eased brightness ramp testbench: clock, reset, stimulus and verdict.
module eased_brightness_ramp_tb;
   import erb_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 20;
   localparam int LONG_HOLD     = 400;
   localparam int ITEM_TARGET   = 1250;
   localparam int HOLD_PHASE    = 3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_operation = OP_TICK;
   logic [LEVEL_W-1:0]   req_target = '0;
   logic [LEVEL_W-1:0]   req_current_level = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [LEVEL_W-1:0]   rsp_level;

   int failures;
   int pending_levels;
   int items_sent;
   bit send_fast;
   bit hold_off_due;

   always #2 clock = ~clock;

   eased_brightness_ramp dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_target        (req_target),
      .req_current_level (req_current_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_level         (rsp_level)
   );

   erb_level_checker level_check (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_target        (req_target),
      .req_current_level (req_current_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_level         (rsp_level),
      .failures          (failures),
      .pending_levels    (pending_levels)
   );

   // Give up if the run hangs
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Offer one item, hold it until taken, then idle for a drawn gap
   task automatic send_item(input logic op, input logic [LEVEL_W-1:0] tgt,
                            input logic [LEVEL_W-1:0] cur);
      int gap;
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_target        <= tgt;
      req_current_level <= cur;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (items_sent % 50 == 0)
         send_fast = ($urandom_range(0, 3) == 0);
      gap = send_fast ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Start a ramp, then tick it a number of times
   task automatic run_ramp(input logic [LEVEL_W-1:0] tgt, input logic [LEVEL_W-1:0] cur,
                           input int ticks);
      send_item(OP_SET, tgt, cur);
      repeat (ticks) send_item(OP_TICK, LEVEL_W'($urandom), LEVEL_W'($urandom));
   endtask

   // Stop sending and wait until every expected level is back and the block idles
   task automatic drain_results;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_levels != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; valid stays high for a following write
   task automatic csr_beat(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Program length and easing, optionally poking the unused index as well
   task automatic write_regs(input logic [LEN_W-1:0] len, input logic [CSR_DAT_W-1:0] ease_word,
                             input bit with_spare);
      csr_beat(CSR_RAMP_LENGTH, len);
      csr_beat(CSR_EASING, ease_word);
      if (with_spare)
         csr_beat(CSR_SPARE, CSR_DAT_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Levels lean toward the extremes now and then
   function automatic logic [LEVEL_W-1:0] pick_level();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return LEVEL_W'($urandom);
      endcase
   endfunction

   // Receiver: stall a drawn number of cycles before each item, once a long hold
   initial begin : receiver
      int gap;
      int taken;
      bit fast;
      bit hold_done;
      taken     = 0;
      fast      = 1'b0;
      hold_done = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_due && !hold_done) begin
            hold_done = 1'b1;
            gap       = LONG_HOLD;
         end else begin
            gap = fast ? 0 : $urandom_range(0, 16);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
         if (taken % 40 == 0)
            fast = ($urandom_range(0, 2) == 0);
      end
   end

   // Stimulus: directed cases, then random phases under changing settings
   initial begin : stimulus
      int                 phase;
      int                 phase_end;
      int                 tick_max;
      logic [LEN_W-1:0]   len;
      logic [EASE_W-1:0]  ease;
      items_sent   = 0;
      send_fast    = 1'b0;
      hold_off_due = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: no difference stored, so ticks give the start level
      send_item(OP_TICK, '0, '0);
      run_ramp(8'd255, 8'd0, 2);
      run_ramp(8'd0, 8'd255, 2);
      run_ramp(8'd77, 8'd77, 1);
      drain_results;

      // short linear ramp, ticked past its end
      write_regs(16'd5, 16'd0, 1'b1);
      run_ramp(8'd200, 8'd10, 6);
      drain_results;

      // one-tick ramp ends at once; easing word with its upper bits set
      write_regs(16'd1, 16'hFFFF, 1'b0);
      run_ramp(8'd255, 8'd0, 1);
      drain_results;

      // longest ramp with the strongest easing
      write_regs(16'hFFFF, 16'h00FF, 1'b0);
      run_ramp(8'd0, 8'd255, 3);
      drain_results;

      // lower the length below the count, then raise it past the count again
      write_regs(16'd2, 16'h0080, 1'b0);
      send_item(OP_TICK, '0, '0);
      drain_results;
      write_regs(16'd20, 16'h0040, 1'b0);
      send_item(OP_TICK, '0, '0);
      drain_results;

      // zero length: every tick ends the ramp
      write_regs(16'd0, 16'h0080, 1'b0);
      run_ramp(8'd9, 8'd250, 1);
      drain_results;

      // random phases, each with its own settings
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0:       len = 16'd1;
            1:       len = 16'hFFFF;
            2:       len = LEN_W'($urandom_range(100, 3000));
            default: len = LEN_W'($urandom_range(2, 40));
         endcase
         case ($urandom_range(0, 5))
            0:       ease = '0;
            1:       ease = '1;
            default: ease = EASE_W'($urandom);
         endcase
         if (phase == HOLD_PHASE) begin
            len          = 16'd2000;
            hold_off_due = 1'b1;
         end
         write_regs(len, {8'($urandom), ease}, (phase % 5) == 0);
         tick_max  = ((len < 60) ? int'(len) : 60) + 3;
         phase_end = items_sent + $urandom_range(40, 120);
         while (items_sent < phase_end) begin
            // mostly whole ramps, some loose items in between
            if ($urandom_range(0, 7) == 0)
               send_item(1'($urandom_range(0, 1)), LEVEL_W'($urandom), LEVEL_W'($urandom));
            else
               run_ramp(pick_level(), pick_level(), $urandom_range(0, tick_max));
         end
         drain_results;
         phase++;
      end

      if (failures == 0 && pending_levels == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
